// File: src/gds_pkg.sv
// ----------------------------------------------------------------------------
// gds_pkg: shared types, constants and calendar functions
//
// Field widths, item modes and the Gregorian helpers for the date stepper.
// ----------------------------------------------------------------------------
package gds_pkg;

  // Field widths of the item and result payloads.
  localparam int MODE_W  = 2;
  localparam int YEAR_W  = 14;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;

  // Calendar limits.
  localparam logic [YEAR_W-1:0]  YEAR_MAX   = YEAR_W'(9999);
  localparam logic [YEAR_W-1:0]  YEAR_INIT  = YEAR_W'(1970);
  localparam logic [MONTH_W-1:0] MONTH_FIRST = MONTH_W'(1);
  localparam logic [MONTH_W-1:0] MONTH_LAST  = MONTH_W'(12);
  localparam logic [MONTH_W-1:0] MONTH_FEB   = MONTH_W'(2);
  localparam logic [MONTH_W-1:0] MONTH_APR   = MONTH_W'(4);
  localparam logic [MONTH_W-1:0] MONTH_JUN   = MONTH_W'(6);
  localparam logic [MONTH_W-1:0] MONTH_SEP   = MONTH_W'(9);
  localparam logic [MONTH_W-1:0] MONTH_NOV   = MONTH_W'(11);
  localparam logic [DAY_W-1:0]   DAY_FIRST   = DAY_W'(1);
  localparam logic [DAY_W-1:0]   DAYS_FEB    = DAY_W'(28);
  localparam logic [DAY_W-1:0]   DAYS_SHORT  = DAY_W'(30);
  localparam logic [DAY_W-1:0]   DAYS_LONG   = DAY_W'(31);

  // Reciprocal of 100: floor(y * 5243 / 2^19) equals floor(y / 100) for
  // every 14-bit year.
  localparam int DIV100_SHIFT = 19;
  localparam int DIV100_MUL   = 5243;
  localparam int PROD_W       = YEAR_W + 13;
  localparam int CENT_W       = PROD_W - DIV100_SHIFT;

  // What one input item asks for.
  typedef enum logic [MODE_W-1:0] {
    MODE_LOAD = 2'd0,
    MODE_NEXT = 2'd1,
    MODE_PREV = 2'd2,
    MODE_READ = 2'd3
  } mode_t;

  // Gregorian leap rule: divisible by 4, except by 100, unless by 400.
  function automatic logic leap_of(input logic [YEAR_W-1:0] y);
    logic [PROD_W-1:0] prod;
    logic [CENT_W-1:0] cent;
    logic [YEAR_W-1:0] rem;
    prod = PROD_W'(y) * PROD_W'(DIV100_MUL);
    cent = prod[PROD_W-1:DIV100_SHIFT];
    rem  = y - YEAR_W'(YEAR_W'(cent) * YEAR_W'(100));
    if (rem == '0) begin
      return (cent[1:0] == 2'b00);
    end
    return (y[1:0] == 2'b00);
  endfunction

  // Days in a month; codes outside 1..12 read as a long month.
  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
    logic [DAY_W-1:0] n;
    case (m)
      MONTH_FEB: n = leap ? DAYS_FEB + DAY_W'(1) : DAYS_FEB;
      MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: n = DAYS_SHORT;
      default: n = DAYS_LONG;
    endcase
    return n;
  endfunction

endpackage

// File: src/gds_ifs.sv
// ----------------------------------------------------------------------------
// gds channel interfaces
//
// Valid/ready channels for command items and date result items.
// ----------------------------------------------------------------------------
interface gds_cmd_if;
  import gds_pkg::*;

  logic               valid;
  logic               ready;
  logic [MODE_W-1:0]  mode;
  logic [YEAR_W-1:0]  load_year;
  logic [MONTH_W-1:0] load_month;
  logic [DAY_W-1:0]   load_day;

  modport source (output valid, mode, load_year, load_month, load_day, input ready);
  modport sink   (input valid, mode, load_year, load_month, load_day, output ready);
endinterface

interface gds_date_if;
  import gds_pkg::*;

  logic               valid;
  logic               ready;
  logic [YEAR_W-1:0]  year;
  logic [MONTH_W-1:0] month;
  logic [DAY_W-1:0]   day;
  logic [DAY_W-1:0]   month_length;
  logic               leap_year;

  modport source (output valid, year, month, day, month_length, leap_year, input ready);
  modport sink   (input valid, year, month, day, month_length, leap_year, output ready);
endinterface

// File: src/gregorian_date_stepper.sv
// ----------------------------------------------------------------------------
// gregorian_date_stepper: calendar date register with day stepping
//
// Holds a Gregorian date; each item loads it, steps it a day either way or
// just reads it, and yields the date with its month length and leap flag.
//
//   channel | dir | payload
//   --------+-----+-------------------------------------------------------
//   cmd     | in  | mode, load_year, load_month, load_day
//   date    | out | year, month, day, month_length, leap_year
//
// One item per cycle unless a result is stalled; its result shows in the cycle after acceptance.
// The date registers double as the result register, so a result stalled
// on the output holds while cmd.ready stays low until it is taken.
// Reset gives 1970-01-01 and an empty output.
// ----------------------------------------------------------------------------
module gregorian_date_stepper (
  input  logic              clk,
  input  logic              rst,
  gds_cmd_if.sink           cmd,
  gds_date_if.source        date
);
  import gds_pkg::*;

  // Date state, also the registered result.
  logic [YEAR_W-1:0]  year,  year_next;
  logic [MONTH_W-1:0] month, month_next;
  logic [DAY_W-1:0]   day,   day_next;
  logic [DAY_W-1:0]   mlen,  mlen_next;
  logic               leap,  leap_next;
  logic               out_valid;

  logic               accept;
  mode_t              mode;
  logic [YEAR_W-1:0]  ld_year;
  logic [MONTH_W-1:0] ld_month;
  logic [DAY_W-1:0]   ld_day;
  logic [DAY_W-1:0]   ld_len;

  // Accept whenever the result slot is free or being emptied.
  assign cmd.ready = !out_valid || date.ready;
  assign accept    = cmd.valid && cmd.ready;
  assign mode      = mode_t'(cmd.mode);

  // Load operands clamped to a valid month; day is clamped below.
  always_comb begin
    ld_year  = (cmd.load_year > YEAR_MAX) ? YEAR_MAX : cmd.load_year;
    ld_month = cmd.load_month;
    if (cmd.load_month < MONTH_FIRST) begin
      ld_month = MONTH_FIRST;
    end else if (cmd.load_month > MONTH_LAST) begin
      ld_month = MONTH_LAST;
    end
  end

  // Next year and month first, then the leap flag of the new year, then day.
  always_comb begin
    year_next  = year;
    month_next = month;
    day_next   = day;
    case (mode)
      MODE_LOAD: begin
        year_next  = ld_year;
        month_next = ld_month;
      end
      MODE_NEXT: begin
        if (day < mlen) begin
          day_next = day + DAY_W'(1);
        end else begin
          day_next = DAY_FIRST;
          if (month < MONTH_LAST) begin
            month_next = month + MONTH_W'(1);
          end else begin
            month_next = MONTH_FIRST;
            year_next  = (year >= YEAR_MAX) ? '0 : year + YEAR_W'(1);
          end
        end
      end
      MODE_PREV: begin
        if (day > DAY_FIRST) begin
          day_next = day - DAY_W'(1);
        end else if (month > MONTH_FIRST) begin
          month_next = month - MONTH_W'(1);
        end else begin
          month_next = MONTH_LAST;
          year_next  = (year == '0) ? YEAR_MAX : year - YEAR_W'(1);
        end
      end
      default: begin
      end
    endcase

    leap_next = leap_of(year_next);
    mlen_next = month_len(month_next, leap_next);
    ld_len    = mlen_next;

    // Day fixes that need the new month length.
    if (mode == MODE_LOAD) begin
      if (cmd.load_day < DAY_FIRST) begin
        day_next = DAY_FIRST;
      end else if (cmd.load_day > ld_len) begin
        day_next = ld_len;
      end else begin
        day_next = cmd.load_day;
      end
    end else if (mode == MODE_PREV && day == DAY_FIRST) begin
      day_next = mlen_next;
    end
  end

  // Date registers update on every accepted item.
  always_ff @(posedge clk) begin
    if (rst) begin
      year  <= YEAR_INIT;
      month <= MONTH_FIRST;
      day   <= DAY_FIRST;
      mlen  <= DAYS_LONG;
      leap  <= 1'b0;
    end else if (accept) begin
      year  <= year_next;
      month <= month_next;
      day   <= day_next;
      mlen  <= mlen_next;
      leap  <= leap_next;
    end
  end

  // Result valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (date.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign date.valid        = out_valid;
  assign date.year         = year;
  assign date.month        = month;
  assign date.day          = day;
  assign date.month_length = mlen;
  assign date.leap_year    = leap;

endmodule

// File: tb/sv/gds_date_checker.sv
// ----------------------------------------------------------------------------
// gds_date_checker: scoreboard for the Gregorian date stepper
//
// Watches both channels, keeps its own copy of the held date, predicts the
// result of every accepted command item and compares each accepted result
// item against the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module gds_date_checker (
  input  logic clk,
  input  logic rst,
  gds_cmd_if   cmd,
  gds_date_if  date,
  output int   fail_count,
  output int   pending
);
  import gds_pkg::*;

  localparam int SHOWN_MAX = 10;

  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
    logic [DAY_W-1:0]   month_length;
    logic               leap_year;
  } date_rec_t;

  // Common-year month lengths, indexed by the 4-bit month code.
  localparam logic [DAY_W-1:0] BASE_DAYS [16] = '{
    5'd31, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31,
    5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd31, 5'd31, 5'd31
  };

  date_rec_t held;
  date_rec_t due_dates [$];
  int        errors = 0;

  function automatic logic gregorian_leap(input logic [YEAR_W-1:0] y);
    return ((y % 400) == 0) || (((y % 100) != 0) && ((y % 4) == 0));
  endfunction

  function automatic logic [DAY_W-1:0] days_in_month(input logic [YEAR_W-1:0] y,
                                                     input logic [MONTH_W-1:0] m);
    logic [DAY_W-1:0] n;
    n = BASE_DAYS[m];
    if (m == MONTH_FEB && gregorian_leap(y)) begin
      n = n + DAY_W'(1);
    end
    return n;
  endfunction

  // Next held date for one command item, with the derived fields filled in.
  function automatic date_rec_t step_date(input date_rec_t cur, input mode_t md,
                                          input logic [YEAR_W-1:0] ly,
                                          input logic [MONTH_W-1:0] lm,
                                          input logic [DAY_W-1:0] ld);
    date_rec_t nxt;
    logic [DAY_W-1:0] len;
    nxt = cur;
    case (md)
      MODE_LOAD: begin
        nxt.year  = (ly > YEAR_MAX) ? YEAR_MAX : ly;
        nxt.month = (lm == '0) ? MONTH_FIRST : ((lm > MONTH_LAST) ? MONTH_LAST : lm);
        len = days_in_month(nxt.year, nxt.month);
        nxt.day = (ld == '0) ? DAY_FIRST : ((ld > len) ? len : ld);
      end
      MODE_NEXT: begin
        if (cur.day < days_in_month(cur.year, cur.month)) begin
          nxt.day = cur.day + DAY_W'(1);
        end else begin
          nxt.day = DAY_FIRST;
          if (cur.month < MONTH_LAST) begin
            nxt.month = cur.month + MONTH_W'(1);
          end else begin
            nxt.month = MONTH_FIRST;
            nxt.year  = (cur.year >= YEAR_MAX) ? '0 : cur.year + YEAR_W'(1);
          end
        end
      end
      MODE_PREV: begin
        if (cur.day > DAY_FIRST) begin
          nxt.day = cur.day - DAY_W'(1);
        end else begin
          if (cur.month > MONTH_FIRST) begin
            nxt.month = cur.month - MONTH_W'(1);
          end else begin
            nxt.month = MONTH_LAST;
            nxt.year  = (cur.year == '0) ? YEAR_MAX : cur.year - YEAR_W'(1);
          end
          nxt.day = days_in_month(nxt.year, nxt.month);
        end
      end
      default: begin
      end
    endcase
    nxt.month_length = days_in_month(nxt.year, nxt.month);
    nxt.leap_year    = gregorian_leap(nxt.year);
    return nxt;
  endfunction

  // Predict on every accepted command item, compare on every accepted result.
  always @(posedge clk) begin
    date_rec_t got;
    date_rec_t want;
    if (rst) begin
      held = '{YEAR_INIT, MONTH_FIRST, DAY_FIRST, DAYS_LONG, 1'b0};
      due_dates.delete();
    end else begin
      if (cmd.valid && cmd.ready) begin
        held = step_date(held, mode_t'(cmd.mode), cmd.load_year, cmd.load_month,
                         cmd.load_day);
        due_dates.push_back(held);
      end
      if (date.valid && date.ready) begin
        got = '{date.year, date.month, date.day, date.month_length, date.leap_year};
        if (due_dates.size() == 0) begin
          if (errors < SHOWN_MAX) begin
            $display("unexpected date item: %0d-%0d-%0d len %0d leap %0d",
                     got.year, got.month, got.day, got.month_length, got.leap_year);
          end
          errors++;
        end else begin
          want = due_dates.pop_front();
          if (got.year !== want.year || got.month !== want.month ||
              got.day !== want.day || got.month_length !== want.month_length ||
              got.leap_year !== want.leap_year) begin
            if (errors < SHOWN_MAX) begin
              $display("date mismatch: expected %0d-%0d-%0d len %0d leap %0d,",
                       want.year, want.month, want.day, want.month_length,
                       want.leap_year,
                       " got %0d-%0d-%0d len %0d leap %0d",
                       got.year, got.month, got.day,
                       got.month_length, got.leap_year);
            end
            errors++;
          end
        end
      end
    end
    fail_count <= errors;
    pending    <= due_dates.size();
  end

endmodule

// File: tb/sv/gregorian_date_stepper_test.sv
// ----------------------------------------------------------------------------
// gregorian_date_stepper_test: top-level testbench of the date stepper
//
// Drives directed command items at the calendar corners, then random load
// and stepping runs in bursts with gaps, while the result side stalls on
// its own changing pattern. A checker beside the block scores the results.
// ----------------------------------------------------------------------------
module gregorian_date_stepper_test;
  import gds_pkg::*;

  localparam int ITEM_COUNT = 650;
  localparam int RUN_LIMIT  = 2_000_000;

  logic clk;
  logic rst;
  int   fail_count;
  int   pending;
  int   burst_left = 0;

  gds_cmd_if  cmd_ch ();
  gds_date_if date_ch ();

  gregorian_date_stepper dut (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd_ch),
    .date (date_ch)
  );

  gds_date_checker chk (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd_ch),
    .date       (date_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // Free-running clock.
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Result side: a new stall style is drawn whenever the current one runs out.
  int stall_style = 0;
  int stall_left  = 0;
  int stall_phase = 0;

  initial date_ch.ready = 1'b0;

  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_style = $urandom_range(0, 3);
      stall_left  = $urandom_range(32, 200);
    end else begin
      stall_left--;
    end
    stall_phase++;
    case (stall_style)
      0: date_ch.ready <= 1'b1;
      1: date_ch.ready <= ($urandom_range(0, 3) != 0);
      2: date_ch.ready <= ($urandom_range(0, 3) == 0);
      default: date_ch.ready <= ((stall_phase % 7) == 0);
    endcase
  end

  // Offer one command item and hold it until it is taken; most bursts end in gaps.
  task automatic send_item(input mode_t md, input int y, input int m, input int d);
    int gap;
    cmd_ch.valid      <= 1'b1;
    cmd_ch.mode       <= md;
    cmd_ch.load_year  <= YEAR_W'(y);
    cmd_ch.load_month <= MONTH_W'(m);
    cmd_ch.load_day   <= DAY_W'(d);
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        cmd_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Stimulus and verdict.
  initial begin
    int    sent;
    int    y;
    int    m;
    int    d;
    int    run_len;
    int    r;
    bit    fwd;
    mode_t md;

    rst               = 1'b1;
    cmd_ch.valid      = 1'b0;
    cmd_ch.mode       = MODE_READ;
    cmd_ch.load_year  = '0;
    cmd_ch.load_month = '0;
    cmd_ch.load_day   = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed corners: reset date, year wraps, leap rule, load saturation.
    send_item(MODE_READ, 0, 0, 0);
    send_item(MODE_LOAD, 9999, 12, 31);
    send_item(MODE_NEXT, 16383, 15, 31);
    send_item(MODE_PREV, 0, 0, 0);
    send_item(MODE_LOAD, 0, 1, 1);
    send_item(MODE_PREV, 16383, 15, 31);
    send_item(MODE_LOAD, 16383, 0, 0);
    send_item(MODE_LOAD, 2021, 15, 31);
    send_item(MODE_LOAD, 2000, 2, 31);
    send_item(MODE_NEXT, 0, 0, 0);
    send_item(MODE_LOAD, 1900, 2, 30);
    send_item(MODE_NEXT, 0, 0, 0);
    send_item(MODE_LOAD, 2024, 2, 29);
    send_item(MODE_NEXT, 0, 0, 0);
    send_item(MODE_PREV, 0, 0, 0);
    send_item(MODE_LOAD, 2100, 3, 1);
    send_item(MODE_PREV, 0, 0, 0);
    send_item(MODE_LOAD, 0, 2, 31);
    send_item(MODE_LOAD, 2021, 4, 31);
    send_item(MODE_NEXT, 0, 0, 0);
    send_item(MODE_LOAD, 2023, 12, 31);
    send_item(MODE_NEXT, 0, 0, 0);
    send_item(MODE_PREV, 0, 0, 0);
    send_item(MODE_READ, 16383, 15, 31);

    // Random part: a load, often near some corner, then a run of steps mostly one way.
    sent = 0;
    while (sent < ITEM_COUNT) begin
      fwd = $urandom_range(0, 1);
      case ($urandom_range(0, 4))
        0: y = $urandom_range(0, 9999);
        1: y = $urandom_range(0, 99) * 100;
        2: y = $urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom_range(9996, 9999);
        3: y = $urandom_range(0, 16383);
        default: y = $urandom_range(0, 2499) * 4;
      endcase
      m = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 12);
      d = $urandom_range(0, 1) ? $urandom_range(26, 31) : $urandom_range(0, 31);
      if ($urandom_range(0, 7) == 0) begin
        m = fwd ? 12 : 1;
        d = fwd ? 31 : 1;
      end
      send_item(MODE_LOAD, y, m, d);
      sent++;

      run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 120) : $urandom_range(1, 30);
      repeat (run_len) begin
        r = $urandom_range(0, 9);
        if (r < 7) begin
          md = fwd ? MODE_NEXT : MODE_PREV;
        end else if (r < 9) begin
          md = fwd ? MODE_PREV : MODE_NEXT;
        end else begin
          md = MODE_READ;
        end
        send_item(md, $urandom_range(0, 16383), $urandom_range(0, 15),
                  $urandom_range(0, 31));
        sent++;
      end
    end
    cmd_ch.valid <= 1'b0;

    // Drain the outstanding results, then allow for the block's latency.
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("gregorian_date_stepper_test: clean");
    end else begin
      $display("gregorian_date_stepper_test: errors");
    end
    $finish;
  end

  // Hard stop in case the handshakes hang.
  initial begin
    #(RUN_LIMIT);
    $display("gregorian_date_stepper_test: errors");
    $finish;
  end

endmodule
